### rtl/core/assert_macros.svh
// Assertion macros shared by the validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, held off during reset.
`define DNSV_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define DNSV_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dnsv_pkg.sv
// Types, constants and helper functions for the domain name validator.
`default_nettype none

package dnsv_pkg;

    localparam int MAX_NAME_LEN  = 253;
    localparam int MAX_LABEL_LEN = 63;

    // configuration register indexes
    localparam logic CFG_BYPASS_POLICY = 1'b0;
    localparam logic CFG_CHECK_ENABLE  = 1'b1;

    // check bit positions (check_enable / failed_checks)
    localparam int CHK_RFC1035      = 0;
    localparam int CHK_DOUBLE_HYPH  = 1;
    localparam int CHK_SINGLE_DIGIT = 2;
    localparam int CHK_PUNYCODE     = 3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_NAME  = 2'd1;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;
    localparam logic [1:0] STATUS_POLICY    = 2'd3;

    localparam logic [7:0] CHAR_DOT = 8'h2e;

    typedef enum logic [2:0] {
        CLS_START,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_HYPHEN,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LETTER,
        KIND_DIGIT,
        KIND_HYPHEN
    } kind_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
        logic [3:0] zone_labels;
    } name_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] failed_checks;
        logic [6:0] label_total;
    } result_beat_t;

    // scanner view of the beat being processed
    typedef struct packed {
        logic       name_start;
        logic       close;
        logic [3:0] label_bits;
        logic       form_bad;
        logic [6:0] label_count;
    } scan_t;

    typedef struct packed {
        logic [3:0] rel_fail;
        logic       skip_ge;
    } zone_t;

    function automatic char_class_t classify(input logic [7:0] b);
        char_class_t c;
        if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a))
            c = CLS_LETTER;
        else if (b >= 8'h30 && b <= 8'h39)
            c = CLS_DIGIT;
        else if (b == 8'h2d)
            c = CLS_HYPHEN;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    // "xn--" prefix, one character per position
    function automatic logic [7:0] puny_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h78;
            2'd1:    ch = 8'h6e;
            2'd2:    ch = 8'h2d;
            2'd3:    ch = 8'h2d;
            default: ch = 8'h2d;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dnsv_scan.sv
// Byte scanner: name and label lengths, character classes, per-label check bits.
`default_nettype none

module dnsv_scan
    import dnsv_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        beat_en,
    input  name_beat_t beat,
    output scan_t      scan
);

    localparam logic [6:0] LABEL_SAT = 7'(MAX_LABEL_LEN + 1);
    localparam logic [6:0] LABEL_MAX = 7'(MAX_LABEL_LEN);
    localparam logic [7:0] NAME_MAX  = 8'(MAX_NAME_LEN);

    logic [7:0]  name_len_reg,   name_len_next;
    logic [6:0]  label_len_reg,  label_len_next;
    logic [6:0]  label_cnt_reg,  label_cnt_next;
    char_class_t prev_cls_reg,   prev_cls_next;
    kind_t       first_kind_reg, first_kind_next;
    logic [2:0]  prefix_reg,     prefix_next;
    logic        dbl_hyph_reg,   dbl_hyph_next;
    logic        form_bad_reg,   form_bad_next;

    logic        is_dot;
    logic        do_feed;
    logic        do_close;
    char_class_t cls;
    logic [7:0]  n_len;
    logic [6:0]  c_len;
    char_class_t c_prev;
    kind_t       c_first;
    logic [2:0]  c_prefix;
    logic        c_dbl;
    logic        c_bad;
    logic        k_bad;
    logic [6:0]  k_cnt;
    logic [3:0]  bits;

    always_comb
    begin
        is_dot   = (beat.name_byte == CHAR_DOT);
        // a trailing dot on the last beat is dropped
        do_feed  = !(beat.last_byte && is_dot);
        do_close = (do_feed && is_dot) || beat.last_byte;
        cls      = classify(beat.name_byte);

        n_len = name_len_reg;
        if (do_feed && name_len_reg != 8'hff)
            n_len = name_len_reg + 8'd1;

        c_len    = label_len_reg;
        c_prev   = prev_cls_reg;
        c_first  = first_kind_reg;
        c_prefix = prefix_reg;
        c_dbl    = dbl_hyph_reg;
        c_bad    = form_bad_reg;
        if (do_feed && !is_dot)
        begin
            if (cls == CLS_OTHER)
                c_bad = 1'b1;
            if (label_len_reg == 7'd0)
            begin
                unique case (cls)
                    CLS_LETTER: c_first = KIND_LETTER;
                    CLS_DIGIT:  c_first = KIND_DIGIT;
                    CLS_HYPHEN: c_first = KIND_HYPHEN;
                    default:    c_first = KIND_NONE;
                endcase
                if (cls == CLS_HYPHEN)
                    c_bad = 1'b1;
            end
            if (cls == CLS_HYPHEN && prev_cls_reg == CLS_HYPHEN)
                c_dbl = 1'b1;
            if (label_len_reg < 7'd4 && 7'(prefix_reg) == label_len_reg
                && beat.name_byte == puny_char(label_len_reg[1:0]))
                c_prefix = prefix_reg + 3'd1;
            if (label_len_reg < LABEL_SAT)
                c_len = label_len_reg + 7'd1;
            c_prev = cls;
        end

        // label close
        k_bad = c_bad;
        k_cnt = label_cnt_reg;
        bits  = 4'd0;
        if (do_close)
        begin
            if (c_len == 7'd0 || c_len > LABEL_MAX || c_prev == CLS_HYPHEN)
                k_bad = 1'b1;
            bits[CHK_RFC1035]      = (c_first != KIND_LETTER) || (c_prev == CLS_HYPHEN);
            bits[CHK_DOUBLE_HYPH]  = c_dbl;
            bits[CHK_SINGLE_DIGIT] = (c_len != 7'd1) || (c_first != KIND_DIGIT);
            bits[CHK_PUNYCODE]     = (c_prefix >= 3'd4);
            if (label_cnt_reg != 7'h7f)
                k_cnt = label_cnt_reg + 7'd1;
        end

        scan.name_start  = (name_len_reg == 8'd0);
        scan.close       = do_close;
        scan.label_bits  = bits;
        scan.form_bad    = k_bad || n_len == 8'd0 || n_len > NAME_MAX;
        scan.label_count = k_cnt;

        name_len_next   = name_len_reg;
        label_len_next  = label_len_reg;
        label_cnt_next  = label_cnt_reg;
        prev_cls_next   = prev_cls_reg;
        first_kind_next = first_kind_reg;
        prefix_next     = prefix_reg;
        dbl_hyph_next   = dbl_hyph_reg;
        form_bad_next   = form_bad_reg;
        if (beat_en)
        begin
            if (beat.last_byte)
            begin
                name_len_next   = 8'd0;
                label_len_next  = 7'd0;
                label_cnt_next  = 7'd0;
                prev_cls_next   = CLS_START;
                first_kind_next = KIND_NONE;
                prefix_next     = 3'd0;
                dbl_hyph_next   = 1'b0;
                form_bad_next   = 1'b0;
            end
            else if (do_close)
            begin
                name_len_next   = n_len;
                label_len_next  = 7'd0;
                label_cnt_next  = k_cnt;
                prev_cls_next   = CLS_START;
                first_kind_next = KIND_NONE;
                prefix_next     = 3'd0;
                dbl_hyph_next   = 1'b0;
                form_bad_next   = k_bad;
            end
            else
            begin
                name_len_next   = n_len;
                label_len_next  = c_len;
                prev_cls_next   = c_prev;
                first_kind_next = c_first;
                prefix_next     = c_prefix;
                dbl_hyph_next   = c_dbl;
                form_bad_next   = c_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_len_reg   <= 8'd0;
            label_len_reg  <= 7'd0;
            label_cnt_reg  <= 7'd0;
            prev_cls_reg   <= CLS_START;
            first_kind_reg <= KIND_NONE;
            prefix_reg     <= 3'd0;
            dbl_hyph_reg   <= 1'b0;
            form_bad_reg   <= 1'b0;
        end
        else
        begin
            name_len_reg   <= name_len_next;
            label_len_reg  <= label_len_next;
            label_cnt_reg  <= label_cnt_next;
            prev_cls_reg   <= prev_cls_next;
            first_kind_reg <= first_kind_next;
            prefix_reg     <= prefix_next;
            dbl_hyph_reg   <= dbl_hyph_next;
            form_bad_reg   <= form_bad_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/dnsv_zone.sv
// Zone window: check bits of the newest labels, older ones folded into one accumulator.
`default_nettype none

module dnsv_zone
    import dnsv_pkg::*;
#(
    parameter int MAX_ZONE_LABELS = 15
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        beat_en,
    input  wire        last_byte,
    input  wire  [3:0] zone_labels,
    input  scan_t      scan,
    output zone_t      zone
);

    localparam int SKW = $clog2(MAX_ZONE_LABELS + 1);
    localparam int CW  = (SKW > 4) ? SKW : 4;
    localparam logic [CW-1:0] ZONE_MAX = CW'(MAX_ZONE_LABELS);

    logic [3:0]     flags_reg [MAX_ZONE_LABELS];
    logic [3:0]     flags_next[MAX_ZONE_LABELS];
    logic [3:0]     shifted   [MAX_ZONE_LABELS];
    logic [3:0]     acc_reg,  acc_next,  acc_shift;
    logic [SKW-1:0] skip_reg, skip_next, skip_cur;
    logic [CW-1:0]  zl_ext;
    logic [3:0]     rel;

    always_comb
    begin
        zl_ext = CW'(zone_labels);
        if (scan.name_start)
            skip_cur = (zl_ext > ZONE_MAX) ? SKW'(ZONE_MAX) : SKW'(zl_ext);
        else
            skip_cur = skip_reg;

        // entry 0 is the newest label
        acc_shift = acc_reg;
        for (int i = 0; i < MAX_ZONE_LABELS; i++)
            shifted[i] = flags_reg[i];
        if (scan.close)
        begin
            acc_shift  = acc_reg | flags_reg[MAX_ZONE_LABELS-1];
            shifted[0] = scan.label_bits;
            for (int i = 1; i < MAX_ZONE_LABELS; i++)
                shifted[i] = flags_reg[i-1];
        end

        // labels at or beyond the skip depth belong to the relative name
        rel = acc_shift;
        for (int i = 0; i < MAX_ZONE_LABELS; i++)
            if (SKW'(i) >= skip_cur)
                rel = rel | shifted[i];

        zone.rel_fail = rel;
        zone.skip_ge  = (7'(skip_cur) >= scan.label_count);

        acc_next  = acc_reg;
        skip_next = skip_reg;
        for (int i = 0; i < MAX_ZONE_LABELS; i++)
            flags_next[i] = flags_reg[i];
        if (beat_en)
        begin
            if (last_byte)
            begin
                acc_next  = 4'd0;
                skip_next = '0;
                for (int i = 0; i < MAX_ZONE_LABELS; i++)
                    flags_next[i] = 4'd0;
            end
            else
            begin
                acc_next  = acc_shift;
                skip_next = skip_cur;
                for (int i = 0; i < MAX_ZONE_LABELS; i++)
                    flags_next[i] = shifted[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 4'd0;
            skip_reg <= '0;
            for (int i = 0; i < MAX_ZONE_LABELS; i++)
                flags_reg[i] <= 4'd0;
        end
        else
        begin
            acc_reg  <= acc_next;
            skip_reg <= skip_next;
            for (int i = 0; i < MAX_ZONE_LABELS; i++)
                flags_reg[i] <= flags_next[i];
        end
    end

endmodule

`default_nettype wire

### rtl/core/domain_name_stream_validator_unit.sv
// Top level of the streaming domain name validator.
//
//  channel   direction  handshake                 beat
//  name      in         name_valid / name_stall   name_beat_t: byte, last mark, zone skip
//  result    out        result_valid / result_stall  result_beat_t: status, checks, count
//  cfg       in         cfg_we                    cfg_index, cfg_wdata
//
// One name byte per cycle while name_stall is low. A beat lands in the input register;
// from it the scanner and zone window update, and a last byte loads the result register.
// result_valid rises when the result register loads; a full, stalled one holds it off.
// Reset clears scan, zone, valid and configuration state, not the data registers.
// name_stall rises only when a held last byte finds the result register full and stalled.
`default_nettype none
`include "assert_macros.svh"

module domain_name_stream_validator_unit
    import dnsv_pkg::*;
#(
    parameter int MAX_ZONE_LABELS = 15
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          name_valid,
    output logic         name_stall,
    input  name_beat_t   name_beat,
    output logic         result_valid,
    input  wire          result_stall,
    output result_beat_t result_beat,
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [3:0]   cfg_wdata
);

    logic         hold_valid_reg, hold_valid_next;
    name_beat_t   hold_reg;
    logic         result_valid_reg, result_valid_next;
    result_beat_t result_reg, result_next;
    logic         bypass_policy_reg;
    logic [3:0]   check_enable_reg;

    logic         slot_free;
    logic         proc;
    logic         accept;
    scan_t        scan;
    zone_t        zone;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_policy_reg <= 1'b0;
            check_enable_reg  <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYPASS_POLICY: bypass_policy_reg <= cfg_wdata[0];
                CFG_CHECK_ENABLE:  check_enable_reg  <= cfg_wdata;
            endcase
        end
    end

    // non-final bytes never need the result slot
    assign slot_free  = !result_valid_reg || !result_stall;
    assign proc       = hold_valid_reg && (!hold_reg.last_byte || slot_free);
    assign name_stall = hold_valid_reg && !proc;
    assign accept     = name_valid && !name_stall;

    dnsv_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_en (proc),
        .beat    (hold_reg),
        .scan    (scan)
    );

    dnsv_zone #(
        .MAX_ZONE_LABELS (MAX_ZONE_LABELS)
    ) u_zone (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_en     (proc),
        .last_byte   (hold_reg.last_byte),
        .zone_labels (hold_reg.zone_labels),
        .scan        (scan),
        .zone        (zone)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (proc)
            hold_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (proc && hold_reg.last_byte)
        begin
            result_valid_next = 1'b1;
            priority if (scan.form_bad)
            begin
                result_next.status        = STATUS_BAD_NAME;
                result_next.failed_checks = 4'd0;
                result_next.label_total   = 7'd0;
            end
            else if (zone.skip_ge)
            begin
                result_next.status        = STATUS_BAD_COUNT;
                result_next.failed_checks = 4'd0;
                result_next.label_total   = scan.label_count;
            end
            else
            begin
                result_next.failed_checks = zone.rel_fail;
                result_next.label_total   = scan.label_count;
                if (!bypass_policy_reg && (zone.rel_fail & check_enable_reg) != 4'd0)
                    result_next.status = STATUS_POLICY;
                else
                    result_next.status = STATUS_OK;
            end
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= name_beat;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;

    `DNSV_ASSERT(a_bad_name_empty, clk, rst_n, result_valid_reg && result_reg.status == STATUS_BAD_NAME |-> result_reg.failed_checks == 4'd0 && result_reg.label_total == 7'd0, "bad name result carries data")
    `DNSV_ASSERT(a_policy_cause, clk, rst_n, result_valid_reg && result_reg.status == STATUS_POLICY |-> !bypass_policy_reg && (result_reg.failed_checks & check_enable_reg) != 4'd0, "policy reject without enabled failure")
    `DNSV_ASSERT(a_count_no_checks, clk, rst_n, result_valid_reg && result_reg.status == STATUS_BAD_COUNT |-> result_reg.failed_checks == 4'd0, "label count reject reports checks")
    `DNSV_ASSERT_NEXT(a_clear_after_last, clk, rst_n, proc && hold_reg.last_byte, scan.name_start, "name state not cleared after last byte")

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the streaming domain name validator.
`timescale 1ns / 1ps

import dnsv_pkg::*;

localparam int ZONE_WINDOW = 15;
localparam logic [31:0] PUNY_TAG = "xn--";

typedef logic [7:0] name_text_t[$];

class name_status_scoreboard;
    logic         policy_off;
    logic [3:0]   checks_on;
    int unsigned  mismatches;
    result_beat_t expected_status[$];

    // per-name scan state
    int unsigned  name_len;
    int unsigned  lbl_len;
    int unsigned  lbl_count;
    int unsigned  tag_pos;
    int unsigned  skip_count;
    char_class_t  prev_cls;
    kind_t        head_kind;
    logic         dbl_hyphen;
    logic         bad_form;
    logic [3:0]   shifted_flags;
    logic [3:0]   window_flags[ZONE_WINDOW];

    function new();
        policy_off = 1'b0;
        checks_on = 4'h0;
        mismatches = 0;
        restart_name();
    endfunction

    function void restart_name();
        name_len = 0;
        lbl_len = 0;
        lbl_count = 0;
        tag_pos = 0;
        skip_count = 0;
        prev_cls = CLS_START;
        head_kind = KIND_NONE;
        dbl_hyphen = 1'b0;
        bad_form = 1'b0;
        shifted_flags = 4'h0;
        foreach (window_flags[i])
            window_flags[i] = 4'h0;
    endfunction

    function char_class_t class_of(logic [7:0] b);
        if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
            return CLS_LETTER;
        if (b >= "0" && b <= "9")
            return CLS_DIGIT;
        if (b == "-")
            return CLS_HYPHEN;
        return CLS_OTHER;
    endfunction

    function void end_label();
        logic [3:0] flags;
        flags = 4'h0;
        flags[CHK_DOUBLE_HYPH] = dbl_hyphen;
        if (lbl_len == 0 || lbl_len > MAX_LABEL_LEN || prev_cls == CLS_HYPHEN)
            bad_form = 1'b1;
        if (head_kind != KIND_LETTER || prev_cls == CLS_HYPHEN)
            flags[CHK_RFC1035] = 1'b1;
        if (lbl_len != 1 || head_kind != KIND_DIGIT)
            flags[CHK_SINGLE_DIGIT] = 1'b1;
        if (tag_pos >= 4)
            flags[CHK_PUNYCODE] = 1'b1;
        // oldest label falls out of the zone window into the relative part
        shifted_flags |= window_flags[ZONE_WINDOW - 1];
        for (int i = ZONE_WINDOW - 1; i > 0; i--)
            window_flags[i] = window_flags[i - 1];
        window_flags[0] = flags;
        if (lbl_count < 127)
            lbl_count++;
        lbl_len = 0;
        prev_cls = CLS_START;
        head_kind = KIND_NONE;
        tag_pos = 0;
        dbl_hyphen = 1'b0;
    endfunction

    function void scan_char(logic [7:0] b);
        char_class_t cls;
        if (name_len < 255)
            name_len++;
        if (b == CHAR_DOT)
        begin
            end_label();
            return;
        end
        cls = class_of(b);
        if (cls == CLS_OTHER)
            bad_form = 1'b1;
        if (lbl_len == 0)
        begin
            case (cls)
                CLS_LETTER: head_kind = KIND_LETTER;
                CLS_DIGIT:  head_kind = KIND_DIGIT;
                CLS_HYPHEN:
                begin
                    head_kind = KIND_HYPHEN;
                    bad_form = 1'b1;
                end
                default:    head_kind = KIND_NONE;
            endcase
        end
        if (cls == CLS_HYPHEN && prev_cls == CLS_HYPHEN)
            dbl_hyphen = 1'b1;
        if (lbl_len < 4 && tag_pos == lbl_len && b == PUNY_TAG[31 - 8 * lbl_len -: 8])
            tag_pos++;
        if (lbl_len < MAX_LABEL_LEN + 1)
            lbl_len++;
        prev_cls = cls;
    endfunction

    function void take_name_byte(name_beat_t nb);
        result_beat_t r;
        logic [3:0]   rel;
        if (name_len == 0)
            skip_count = (nb.zone_labels > ZONE_WINDOW) ? ZONE_WINDOW : nb.zone_labels;
        // one trailing dot is dropped
        if (!(nb.last_byte && nb.name_byte == CHAR_DOT))
            scan_char(nb.name_byte);
        if (!nb.last_byte)
            return;
        end_label();
        if (name_len < 1 || name_len > MAX_NAME_LEN)
            bad_form = 1'b1;
        rel = shifted_flags;
        for (int i = skip_count; i < ZONE_WINDOW; i++)
            rel |= window_flags[i];
        r = '0;
        if (bad_form)
            r.status = STATUS_BAD_NAME;
        else if (skip_count >= lbl_count)
        begin
            r.status = STATUS_BAD_COUNT;
            r.label_total = 7'(lbl_count);
        end
        else
        begin
            r.failed_checks = rel;
            r.label_total = 7'(lbl_count);
            r.status = (!policy_off && (rel & checks_on) != 4'h0) ? STATUS_POLICY : STATUS_OK;
        end
        expected_status = {expected_status, r};
        restart_name();
    endfunction

    task report(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task check_status(result_beat_t got);
        result_beat_t want;
        if (expected_status.size() == 0)
        begin
            report("result beat with no name pending", 8'h0, 8'(got.status));
            return;
        end
        want = expected_status.pop_front();
        if (got.status !== want.status)
            report("status", 8'(want.status), 8'(got.status));
        if (got.failed_checks !== want.failed_checks)
            report("failed_checks", 8'(want.failed_checks), 8'(got.failed_checks));
        if (got.label_total !== want.label_total)
            report("label_total", 8'(want.label_total), 8'(got.label_total));
    endtask
endclass

module tb_top;
    localparam int QUIET_LIMIT = 4000;
    localparam int SEG_BYTES = 115;
    // {bypass_policy, check_enable} per random segment
    localparam logic [4:0] CFG_PLAN[6] = '{5'h1F, 5'h00, 5'h03, 5'h0C, 5'h10, 5'h0F};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         name_valid = 1'b0;
    logic         name_stall;
    name_beat_t   name_beat = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result_beat;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [3:0]   cfg_wdata = 4'h0;

    int unsigned  send_gap_pct = 29;
    int unsigned  stall_pct = 84;
    int unsigned  quiet_cycles = 0;
    int unsigned  bytes_sent = 0;

    name_status_scoreboard board = new();

    domain_name_stream_validator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .name_valid   (name_valid),
        .name_stall   (name_stall),
        .name_beat    (name_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (name_valid && !name_stall)
                board.take_name_byte(name_beat);
            if (result_valid && !result_stall)
                board.check_status(result_beat);
        end
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((name_valid && !name_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(input name_beat_t nb);
        while ($urandom_range(99) < send_gap_pct)
        begin
            name_valid <= 1'b0;
            @(posedge clk);
        end
        name_valid <= 1'b1;
        name_beat <= nb;
        @(posedge clk);
        while (name_stall)
            @(posedge clk);
    endtask

    // zone_labels only matters on the first byte; the rest carry noise
    task automatic send_name(input name_text_t text, input logic [3:0] zone);
        name_beat_t nb;
        for (int i = 0; i < text.size(); i++)
        begin
            nb.name_byte = text[i];
            nb.last_byte = (i == text.size() - 1);
            nb.zone_labels = (i == 0) ? zone : 4'($urandom_range(15));
            send_beat(nb);
        end
        bytes_sent += text.size();
    endtask

    task automatic send_text(input string s, input logic [3:0] zone);
        name_text_t text;
        for (int i = 0; i < s.len(); i++)
            text = {text, 8'(s[i])};
        send_name(text, zone);
    endtask

    task automatic write_config(input logic bypass, input logic [3:0] enable);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BYPASS_POLICY;
        cfg_wdata <= {3'b000, bypass};
        @(posedge clk);
        cfg_index <= CFG_CHECK_ENABLE;
        cfg_wdata <= enable;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.policy_off = bypass;
        board.checks_on = enable;
    endtask

    task automatic settle_results();
        while (board.expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] random_letter();
        return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] random_host_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return random_letter();
        if (r < 85)
            return "0" + 8'($urandom_range(9));
        return "-";
    endfunction

    function automatic name_text_t make_label();
        name_text_t  lbl;
        int unsigned len, r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            lbl = {lbl, 8'("0" + 8'($urandom_range(9)))};
            return lbl;
        end
        if (r < 72)
            len = $urandom_range(1, 6);
        else if (r < 94)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(62, 64);
        for (int i = 0; i < len; i++)
            lbl = {lbl, random_host_char()};
        if ($urandom_range(99) < 60)
            lbl[0] = random_letter();
        if (len >= 5 && $urandom_range(99) < 15)
        begin
            lbl[0] = ($urandom_range(9) == 0) ? "X" : "x";
            lbl[1] = "n";
            lbl[2] = "-";
            lbl[3] = "-";
        end
        if (len >= 4 && $urandom_range(99) < 10)
        begin
            lbl[1] = "-";
            lbl[2] = "-";
        end
        // keep most labels legal at both ends
        if (lbl[0] == "-" && $urandom_range(99) < 92)
            lbl[0] = random_letter();
        if (lbl[len - 1] == "-" && $urandom_range(99) < 92)
            lbl[len - 1] = "0" + 8'($urandom_range(9));
        return lbl;
    endfunction

    function automatic name_text_t make_name(output logic [3:0] zone);
        name_text_t  text, lbl;
        int unsigned labels, r, pos;
        r = $urandom_range(99);
        labels = $urandom_range(1, 5);
        zone = 4'($urandom_range(15));
        if (r < 10)
        begin
            repeat ($urandom_range(1, 6)) text = {text, 8'($urandom)};
            return text;
        end
        if (r < 13)
        begin
            repeat ($urandom_range(1, 2)) text = {text, CHAR_DOT};
            return text;
        end
        for (int i = 0; i < labels; i++)
        begin
            if (i != 0)
                text = {text, CHAR_DOT};
            lbl = make_label();
            foreach (lbl[j])
                text = {text, lbl[j]};
        end
        if (r < 25)
        begin
            pos = $urandom_range(text.size() - 1);
            case ($urandom_range(2))
                0:       text[pos] = 8'($urandom);
                1:       text.insert(pos, CHAR_DOT);
                default: text.insert(pos, "-");
            endcase
        end
        if ($urandom_range(99) < 25)
            text = {text, CHAR_DOT};
        if ($urandom_range(99) < 75)
            zone = 4'($urandom_range(labels - 1));
        return text;
    endfunction

    initial
    begin
        name_text_t  text;
        logic [3:0]  zone;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_config(1'b0, 4'hF);

        send_text(".", 4'd0);
        send_text("a.", 4'd0);
        send_text("xn--a.b", 4'd1);
        send_text("a-1.b", 4'd2);
        send_text("7.c", 4'd1);
        text = '{8'h00, 8'hFF};
        send_name(text, 4'hF);
        send_text("b-", 4'd0);

        for (int seg = 0; seg < 6; seg++)
        begin
            name_valid <= 1'b0;
            settle_results();
            case (seg / 2)
                0:
                begin
                    send_gap_pct = 29;
                    stall_pct = 84;
                end
                1:
                begin
                    send_gap_pct = 84;
                    stall_pct = 29;
                end
                default:
                begin
                    send_gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            write_config(CFG_PLAN[seg][4], CFG_PLAN[seg][3:0]);
            bytes_sent = 0;
            if (seg == 0)
            begin
                // names at the length limit and one past it
                for (int tail = 61; tail <= 62; tail++)
                begin
                    text.delete();
                    for (int n = 0; n < 3 * 64 + tail; n++)
                        text = {text, ((n % 64 == 63) ? CHAR_DOT : random_letter())};
                    send_name(text, 4'($urandom_range(3)));
                end
                bytes_sent = 0;
            end
            while (bytes_sent < SEG_BYTES)
            begin
                text = make_name(zone);
                send_name(text, zone);
            end
        end
        name_valid <= 1'b0;
        settle_results();

        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
